// ----- design/ssd_pkg.sv -----
// Shared types, register codes and the digit segment table for the
// two-wire seven-segment display driver. No dependencies.
package ssd_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLON_MASK = 3'd3;

    localparam logic [7:0] RST_AUTO_ADDR  = 8'h40;
    localparam logic [7:0] RST_START_ADDR = 8'hC0;
    localparam logic [7:0] RST_DISP_CTRL  = 8'h8F;
    localparam logic [7:0] RST_COLON_MASK = 8'h80;

    localparam int DIGIT_CNT = 4;

    typedef struct packed {
        logic       begin_update;
        logic       final_update;
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic [7:0] char_third;
        logic [7:0] char_fourth;
        logic       segments_enabled;
        logic       dio_sample;
    } in_item_t;

    typedef struct packed {
        logic clk_line;
        logic dio_line;
        logic dio_drive;
        logic busy_res;
        logic ack_error;
        logic done_res;
    } out_item_t;

    typedef struct packed {
        logic [7:0] auto_addr;
        logic [7:0] addr_cmd;
        logic [7:0] disp_ctrl;
        logic [7:0] colon_mask;
    } cfg_regs_t;

    typedef logic [DIGIT_CNT-1:0][7:0] seg_bytes_t;

    // ASCII '0'..'9' to segment pattern, blank otherwise
    function automatic logic [7:0] seg_of_char(input logic [7:0] ch);
        logic [7:0] seg;
        case (ch)
            8'h30:   seg = 8'h3f;
            8'h31:   seg = 8'h06;
            8'h32:   seg = 8'h5b;
            8'h33:   seg = 8'h4f;
            8'h34:   seg = 8'h66;
            8'h35:   seg = 8'h6d;
            8'h36:   seg = 8'h7d;
            8'h37:   seg = 8'h07;
            8'h38:   seg = 8'h7f;
            8'h39:   seg = 8'h67;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- design/ssd_seg_enc.sv -----
// Character to segment encoder for the four display digits.
// Depends on ssd_pkg (item and config types, digit table).
module ssd_seg_enc (
    input  ssd_pkg::in_item_t   item,
    input  ssd_pkg::cfg_regs_t  cfg,
    output ssd_pkg::seg_bytes_t segs
);
    import ssd_pkg::*;

    logic [DIGIT_CNT-1:0][7:0] chars;
    logic                      colon;

    assign chars = {item.char_first, item.char_second, item.char_third, item.char_fourth};
    assign colon = !item.final_update;

    always_comb
    begin
        // segs[0] is the leftmost digit
        for (int i = 0; i < DIGIT_CNT; i++)
        begin
            segs[i] = item.segments_enabled ? seg_of_char(chars[DIGIT_CNT-1-i]) : 8'h00;
            if (colon)
            begin
                segs[i] = segs[i] | cfg.colon_mask;
            end
        end
    end

endmodule

// ----- design/ssd_core.sv -----
// Bit-bang sequencer: one tick per step, holds the transfer state and
// computes the line levels and status for that tick. Depends on ssd_pkg, ssd_seg_enc.
module ssd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ssd_pkg::in_item_t  item,
    input  ssd_pkg::cfg_regs_t cfg,
    output ssd_pkg::out_item_t res
);
    import ssd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START0, PH_START1, PH_START2, PH_BITLOW, PH_BITHIGH,
        PH_ACKLOW, PH_ACKHIGH, PH_STOP0, PH_STOP1, PH_STOP2
    } phase_t;

    localparam logic [1:0] FSEL_AUTO = 2'd0;
    localparam logic [1:0] FSEL_ADDR = 2'd1;
    localparam logic [1:0] FSEL_CTRL = 2'd2;
    localparam logic [2:0] FRAME_LEN_DIGITS = 3'd5;
    localparam logic [2:0] FRAME_LEN_CMD    = 3'd1;
    localparam logic [3:0] BITS_PER_BYTE    = 4'd8;

    phase_t     phase_reg, phase_next, ph;
    logic [3:0] bit_cnt_reg, bit_cnt_next, bit_cnt_inc;
    logic [2:0] fbc_reg, fbc_next, fbc_inc, frame_len;
    logic [1:0] fsel_reg, fsel_next, fsel;
    logic [7:0] shift_reg, shift_next;
    logic       fault_reg, fault_next;
    logic       final_reg, final_next;
    logic       clk_lvl_reg, clk_lvl_next;
    logic       dio_lvl_reg, dio_lvl_next;
    logic       begin_go;
    logic       o_clk, o_dio, o_drive, o_busy, o_done;

    seg_bytes_t segs;
    logic [7:0] seg_latch_reg [DIGIT_CNT];

    ssd_seg_enc u_seg_enc (
        .item (item),
        .cfg  (cfg),
        .segs (segs)
    );

    assign bit_cnt_inc = bit_cnt_reg + 4'd1;
    assign fbc_inc     = fbc_reg + 3'd1;
    assign frame_len   = (fsel == FSEL_ADDR) ? FRAME_LEN_DIGITS : FRAME_LEN_CMD;

    always_comb
    begin
        begin_go   = (phase_reg == PH_IDLE) && item.begin_update;
        ph         = begin_go ? PH_START0 : phase_reg;
        fsel       = begin_go ? (item.final_update ? FSEL_ADDR : FSEL_AUTO) : fsel_reg;
        final_next = begin_go ? item.final_update : final_reg;
        fault_next = begin_go ? 1'b0 : fault_reg;

        phase_next   = ph;
        fsel_next    = fsel;
        bit_cnt_next = bit_cnt_reg;
        fbc_next     = fbc_reg;
        shift_next   = shift_reg;
        o_clk        = clk_lvl_reg;
        o_dio        = dio_lvl_reg;
        o_drive      = 1'b1;
        o_busy       = 1'b1;
        o_done       = 1'b0;
        clk_lvl_next = clk_lvl_reg;
        dio_lvl_next = dio_lvl_reg;

        unique case (ph)
            PH_START0:
            begin
                o_clk = 1'b1; o_dio = 1'b1; phase_next = PH_START1;
            end
            PH_START1:
            begin
                o_clk = 1'b1; o_dio = 1'b0; phase_next = PH_START2;
            end
            PH_START2:
            begin
                o_clk = 1'b0; o_dio = 1'b0;
                fbc_next     = 3'd0;
                bit_cnt_next = 4'd0;
                phase_next   = PH_BITLOW;
                case (fsel)
                    FSEL_AUTO: shift_next = cfg.auto_addr;
                    FSEL_CTRL: shift_next = cfg.disp_ctrl;
                    default:   shift_next = cfg.addr_cmd;
                endcase
            end
            PH_BITLOW:
            begin
                o_clk = 1'b0; o_dio = shift_reg[0]; phase_next = PH_BITHIGH;
            end
            PH_BITHIGH:
            begin
                o_clk = 1'b1; o_dio = shift_reg[0];
                shift_next   = {1'b0, shift_reg[7:1]};
                bit_cnt_next = bit_cnt_inc;
                phase_next   = (bit_cnt_inc >= BITS_PER_BYTE) ? PH_ACKLOW : PH_BITLOW;
            end
            PH_ACKLOW:
            begin
                o_clk = 1'b0; o_dio = 1'b0; o_drive = 1'b0;
                phase_next = PH_ACKHIGH;
                if (item.dio_sample)
                begin
                    // no acknowledge: abort, bus levels go back to idle high
                    fault_next = 1'b1;
                    o_done     = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_ACKHIGH:
            begin
                o_clk = 1'b1; o_dio = 1'b0; o_drive = 1'b0;
                fbc_next = fbc_inc;
                if (fbc_inc < frame_len)
                begin
                    // digit bytes follow the address; byte k+1 is digit k
                    case (fsel)
                        FSEL_AUTO: shift_next = cfg.auto_addr;
                        FSEL_CTRL: shift_next = cfg.disp_ctrl;
                        default:   shift_next = seg_latch_reg[fbc_reg[1:0]];
                    endcase
                    bit_cnt_next = 4'd0;
                    phase_next   = PH_BITLOW;
                end
                else
                begin
                    phase_next = PH_STOP0;
                end
            end
            PH_STOP0:
            begin
                o_clk = 1'b0; o_dio = 1'b0; phase_next = PH_STOP1;
            end
            PH_STOP1:
            begin
                o_clk = 1'b1; o_dio = 1'b0; phase_next = PH_STOP2;
            end
            PH_STOP2:
            begin
                o_clk = 1'b1; o_dio = 1'b1;
                if (final_next || (fsel >= FSEL_CTRL))
                begin
                    o_done     = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    fsel_next  = fsel + 2'd1;
                    phase_next = PH_START0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                o_busy     = 1'b0;
            end
        endcase

        if (ph == PH_ACKLOW && item.dio_sample)
        begin
            clk_lvl_next = 1'b1;
            dio_lvl_next = 1'b1;
        end
        else
        begin
            clk_lvl_next = o_clk;
            if (o_drive)
            begin
                dio_lvl_next = o_dio;
            end
        end

        res.clk_line  = o_clk;
        res.dio_line  = o_drive ? o_dio : 1'b0;
        res.dio_drive = o_drive;
        res.busy_res  = o_busy;
        res.ack_error = fault_next;
        res.done_res  = o_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= 4'd0;
            fbc_reg     <= 3'd0;
            fsel_reg    <= FSEL_AUTO;
            shift_reg   <= 8'h00;
            fault_reg   <= 1'b0;
            final_reg   <= 1'b0;
            clk_lvl_reg <= 1'b1;
            dio_lvl_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            fbc_reg     <= fbc_next;
            fsel_reg    <= fsel_next;
            shift_reg   <= shift_next;
            fault_reg   <= fault_next;
            final_reg   <= final_next;
            clk_lvl_reg <= clk_lvl_next;
            dio_lvl_reg <= dio_lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && begin_go)
        begin
            for (int i = 0; i < DIGIT_CNT; i++)
            begin
                seg_latch_reg[i] <= segs[i];
            end
        end
    end

endmodule

// ----- design/seven_segment_two_wire_driver.sv -----
// Two-wire seven-segment display driver, one bus tick per input beat.
// Each beat passes the input register, the tick logic and then the result register.
// Throughput: one beat per cycle while out_stall is low; tick logic is a single pass.
// Reset (rst_n low, async): bus idle high, no transfer, error flag clear,
// command registers at 0x40 / 0xC0 / 0x8F, colon mask 0x80.
// Depends on ssd_pkg, ssd_core.
module seven_segment_two_wire_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ssd_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ssd_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                      cfg_data
);
    import ssd_pkg::*;

    cfg_regs_t cfg_reg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t res;
    logic      advance;
    logic      in_take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_addr  <= RST_AUTO_ADDR;
            cfg_reg.addr_cmd   <= RST_START_ADDR;
            cfg_reg.disp_ctrl  <= RST_DISP_CTRL;
            cfg_reg.colon_mask <= RST_COLON_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AUTO_ADDR:  cfg_reg.auto_addr  <= cfg_data;
                CFG_START_ADDR: cfg_reg.addr_cmd   <= cfg_data;
                CFG_DISP_CTRL:  cfg_reg.disp_ctrl  <= cfg_data;
                CFG_COLON_MASK: cfg_reg.colon_mask <= cfg_data;
                default:        ;
            endcase
        end
    end

    ssd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_data_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ----- tb/ssd_bus_checker.sv -----
`timescale 1ns / 100ps
// Watches the driver's input, result and register channels, predicts every result
// beat, and compares the results field by field. Depends on ssd_pkg.
module ssd_bus_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  ssd_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  ssd_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            errors,
    output int                            pending
);
    import ssd_pkg::*;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_START_HI,
        BUS_START_FALL,
        BUS_START_LOW,
        BUS_BIT_LOW,
        BUS_BIT_HIGH,
        BUS_ACK_LOW,
        BUS_ACK_HIGH,
        BUS_STOP_LOW,
        BUS_STOP_RISE,
        BUS_STOP_HI
    } bus_phase_t;

    typedef enum logic [1:0] {
        FRAME_CMD,
        FRAME_DIGITS,
        FRAME_CTRL
    } frame_t;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    // segment patterns for '9' down to '0'
    localparam logic [9:0][7:0] GLYPH = {8'h67, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                         8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

    // command registers
    logic [7:0] cmd_auto, cmd_start, cmd_ctrl, colon_bits;

    // bus engine copy
    bus_phase_t  ph;
    frame_t      frame;
    logic [3:0]  nbits;
    logic [2:0]  byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  digit_seg [4];
    logic        fault, is_final, clk_lvl, dio_lvl;

    out_item_t   result_q [$];
    out_item_t   want;
    int          fails;

    function automatic logic [7:0] digit_pattern(input logic [7:0] ch, input logic en,
                                                 input logic colon);
        logic [7:0] v;
        v = 8'h00;
        if (en && ch >= CHAR_ZERO && ch <= CHAR_NINE)
            v = GLYPH[ch[3:0]];
        if (colon)
            v = v | colon_bits;
        return v;
    endfunction

    function automatic logic [7:0] frame_byte_now();
        logic [7:0] v;
        logic [2:0] k;
        k = byte_idx - 3'd1;
        case (frame)
            FRAME_CMD:  v = cmd_auto;
            FRAME_CTRL: v = cmd_ctrl;
            default:    v = (byte_idx == 3'd0) ? cmd_start : digit_seg[k[1:0]];
        endcase
        return v;
    endfunction

    // one bus tick of the driver
    task automatic predict_tick(input in_item_t t, output out_item_t r);
        logic clk_o, dio_o, drv, busy, done, abort, colon;
        drv = 1'b1;
        busy = 1'b1;
        done = 1'b0;
        abort = 1'b0;
        clk_o = clk_lvl;
        dio_o = dio_lvl;
        if (ph == BUS_IDLE && t.begin_update)
        begin
            colon = !t.final_update;
            digit_seg[0] = digit_pattern(t.char_first, t.segments_enabled, colon);
            digit_seg[1] = digit_pattern(t.char_second, t.segments_enabled, colon);
            digit_seg[2] = digit_pattern(t.char_third, t.segments_enabled, colon);
            digit_seg[3] = digit_pattern(t.char_fourth, t.segments_enabled, colon);
            is_final = t.final_update;
            fault = 1'b0;
            frame = t.final_update ? FRAME_DIGITS : FRAME_CMD;
            ph = BUS_START_HI;
        end
        case (ph)
            BUS_START_HI:
            begin
                clk_o = 1'b1; dio_o = 1'b1; ph = BUS_START_FALL;
            end
            BUS_START_FALL:
            begin
                clk_o = 1'b1; dio_o = 1'b0; ph = BUS_START_LOW;
            end
            BUS_START_LOW:
            begin
                clk_o = 1'b0; dio_o = 1'b0;
                byte_idx = 3'd0;
                shreg = frame_byte_now();
                nbits = 4'd0;
                ph = BUS_BIT_LOW;
            end
            BUS_BIT_LOW:
            begin
                clk_o = 1'b0; dio_o = shreg[0]; ph = BUS_BIT_HIGH;
            end
            BUS_BIT_HIGH:
            begin
                clk_o = 1'b1; dio_o = shreg[0];
                shreg = shreg >> 1;
                nbits = nbits + 4'd1;
                ph = (nbits >= 4'd8) ? BUS_ACK_LOW : BUS_BIT_LOW;
            end
            BUS_ACK_LOW:
            begin
                clk_o = 1'b0; dio_o = 1'b0; drv = 1'b0;
                if (t.dio_sample)
                begin
                    // no acknowledge: abort, lines return high
                    fault = 1'b1;
                    done = 1'b1;
                    abort = 1'b1;
                    ph = BUS_IDLE;
                    clk_lvl = 1'b1;
                    dio_lvl = 1'b1;
                end
                else
                    ph = BUS_ACK_HIGH;
            end
            BUS_ACK_HIGH:
            begin
                clk_o = 1'b1; dio_o = 1'b0; drv = 1'b0;
                byte_idx = byte_idx + 3'd1;
                if (byte_idx < ((frame == FRAME_DIGITS) ? 3'd5 : 3'd1))
                begin
                    shreg = frame_byte_now();
                    nbits = 4'd0;
                    ph = BUS_BIT_LOW;
                end
                else
                    ph = BUS_STOP_LOW;
            end
            BUS_STOP_LOW:
            begin
                clk_o = 1'b0; dio_o = 1'b0; ph = BUS_STOP_RISE;
            end
            BUS_STOP_RISE:
            begin
                clk_o = 1'b1; dio_o = 1'b0; ph = BUS_STOP_HI;
            end
            BUS_STOP_HI:
            begin
                clk_o = 1'b1; dio_o = 1'b1;
                if (is_final || frame == FRAME_CTRL)
                begin
                    done = 1'b1;
                    ph = BUS_IDLE;
                end
                else
                begin
                    frame = (frame == FRAME_CMD) ? FRAME_DIGITS : FRAME_CTRL;
                    ph = BUS_START_HI;
                end
            end
            default:
            begin
                ph = BUS_IDLE;
                busy = 1'b0;
            end
        endcase
        if (!abort)
        begin
            clk_lvl = clk_o;
            if (drv)
                dio_lvl = dio_o;
        end
        r.clk_line  = clk_o;
        r.dio_line  = drv ? dio_o : 1'b0;
        r.dio_drive = drv;
        r.busy_res  = busy;
        r.ack_error = fault;
        r.done_res  = done;
    endtask

    task automatic check_field(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_auto   = RST_AUTO_ADDR;
            cmd_start  = RST_START_ADDR;
            cmd_ctrl   = RST_DISP_CTRL;
            colon_bits = RST_COLON_MASK;
            ph = BUS_IDLE;
            frame = FRAME_CMD;
            nbits = 4'd0;
            byte_idx = 3'd0;
            shreg = 8'h00;
            fault = 1'b0;
            is_final = 1'b0;
            clk_lvl = 1'b1;
            dio_lvl = 1'b1;
            result_q.delete();
            fails = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_AUTO_ADDR:  cmd_auto = cfg_data;
                    CFG_START_ADDR: cmd_start = cfg_data;
                    CFG_DISP_CTRL:  cmd_ctrl = cfg_data;
                    CFG_COLON_MASK: colon_bits = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_tick(in_data, want);
                result_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fails++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("clk_line", want.clk_line, out_data.clk_line);
                    check_field("dio_line", want.dio_line, out_data.dio_line);
                    check_field("dio_drive", want.dio_drive, out_data.dio_drive);
                    check_field("busy_res", want.busy_res, out_data.busy_res);
                    check_field("ack_error", want.ack_error, out_data.ack_error);
                    check_field("done_res", want.done_res, out_data.done_res);
                end
            end
            pending <= result_q.size();
            errors <= fails;
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the display driver test: clock, reset, bus tick stimulus, register writes and
// result back-pressure. Depends on ssd_pkg, seven_segment_two_wire_driver, ssd_bus_checker.
module testbench;
    import ssd_pkg::*;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_TICKS = 200;
    localparam int SQUEEZE_LEN = 60;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors;
    int         pending;

    bit         quiet;
    bit         squeeze;

    seven_segment_two_wire_driver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssd_bus_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // result side back-pressure: short random bursts, one long hold on request
    initial
    begin
        int hold_left;
        bit squeeze_seen;
        hold_left = 0;
        squeeze_seen = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeeze_seen)
            begin
                squeeze_seen = 1'b1;
                hold_left = SQUEEZE_LEN - 1;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic in_item_t make_tick(input logic go, input logic fin,
                                           input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2, input logic [7:0] c3,
                                           input logic en, input logic ack_hi);
        in_item_t t;
        t.begin_update     = go;
        t.final_update     = fin;
        t.char_first       = c0;
        t.char_second      = c1;
        t.char_third       = c2;
        t.char_fourth      = c3;
        t.segments_enabled = en;
        t.dio_sample       = ack_hi;
        return t;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 3) != 0)
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly clean transfers with an occasional missing acknowledge, some pure noise
    function automatic in_item_t random_tick();
        if ($urandom_range(0, 9) == 0)
            return make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        return make_tick($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                         pick_char(), pick_char(), pick_char(), pick_char(),
                         $urandom_range(0, 7) != 0, $urandom_range(0, 59) == 0);
    endfunction

    task automatic send_tick(input in_item_t t);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // caller has lowered in_valid in this step
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] phase_value(input int p);
        if (p == 0)
            return 8'h00;
        if (p == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int p, n;
        quiet = 1'b0;
        squeeze = 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_AUTO_ADDR;
        cfg_data <= 8'h00;
        @(posedge rst_n);
        @(posedge clk);

        // normal update with edge characters, begins while busy, abort on the first
        // acknowledge, an idle tick, then a blanked final update
        send_tick(make_tick(1'b1, 1'b0, "0", "9", 8'h00, 8'hFF, 1'b1, 1'b0));
        for (n = 0; n < 19; n++)
            send_tick(make_tick(1'b1, 1'b1, "/", ":", 8'h80, 8'h7F, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b1, "1", "2", "3", "4", 1'b0, 1'b0));
        in_valid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            reg_write(CFG_AUTO_ADDR, phase_value(p));
            reg_write(CFG_START_ADDR, phase_value(p));
            reg_write(CFG_DISP_CTRL, phase_value(p));
            reg_write(CFG_COLON_MASK, phase_value(p));
            // indexes past the last register must be ignored
            reg_write(CFG_COLON_MASK + 3'($urandom_range(1, 4)), 8'($urandom_range(0, 255)));
            cfg_valid <= 1'b0;
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                if (p == 1 && n == 40)
                    squeeze = 1'b1;
                if (p == 2 && n == 100)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending != 0);
                end
                send_tick(random_tick());
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
